/* rtl/llrb_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the line log ring buffer
package llrb_pkg;

   localparam logic [2:0] FN_BEGIN  = 3'd0;
   localparam logic [2:0] FN_BYTE   = 3'd1;
   localparam logic [2:0] FN_READ   = 3'd2;
   localparam logic [2:0] FN_COMMIT = 3'd3;
   localparam logic [2:0] FN_TAKE   = 3'd4;

   localparam logic [7:0] NEWLINE = 8'h0A;

   localparam int LEN_W      = 16;
   localparam int OFFSET_W   = 10;
   localparam int POS_W      = 32;
   localparam int USED_W     = 11;
   localparam int COUNT_W    = 11;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_BEGIN,
      OP_BYTE,
      OP_READ,
      OP_COMMIT,
      OP_TAKE,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ROOM,
      ST_SCAN,
      ST_NEWLINE,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic                too_long;
      logic [LEN_W-1:0]    len;
      logic [7:0]          data;
      logic [OFFSET_W-1:0] offset;
      logic [POS_W-1:0]    target;
   } cmd_type;

   typedef struct packed {
      logic              accepted;
      logic              read_valid;
      logic [7:0]        read_data;
      logic [USED_W-1:0] used_bytes;
      logic [POS_W-1:0]  base_pos;
      logic [POS_W-1:0]  dropped_count;
      logic              line_open;
   } rsp_type;

endpackage

/* rtl/llrb_ram.sv */
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module llrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/llrb_front.sv */
`timescale 1ns / 1ps
// request decode: classifies a transaction into a queued command
module llrb_front #(
   parameter int CAPACITY = 1024
) (
   input  logic                   start,
   input  logic                   q_full,
   input  logic [2:0]             req_func,
   input  logic [15:0]            req_line_len,
   input  logic [7:0]             req_data_byte,
   input  logic [9:0]             req_offset,
   input  logic [31:0]            req_commit_base,
   input  logic [10:0]            req_commit_count,
   output logic                   busy,
   output logic                   push,
   output llrb_pkg::cmd_type      push_cmd
);
   import llrb_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   op_type op;

   always_comb begin
      unique case (req_func)
         FN_BEGIN:  op = OP_BEGIN;
         FN_BYTE:   op = OP_BYTE;
         FN_READ:   op = OP_READ;
         FN_COMMIT: op = OP_COMMIT;
         FN_TAKE:   op = OP_TAKE;
         default:   op = OP_NOP;
      endcase
   end

   assign busy = q_full;
   assign push = start & ~q_full;

   always_comb begin
      push_cmd.op       = op;
      // line plus its newline must fit in the ring
      push_cmd.too_long = {1'b0, req_line_len} >= 17'(CAPACITY);
      push_cmd.len      = LEN_W'(req_line_len[AW-1:0]);
      push_cmd.data     = req_data_byte;
      push_cmd.offset   = req_offset;
      push_cmd.target   = req_commit_base + POS_W'(req_commit_count);
   end

endmodule

/* rtl/llrb_fifo.sv */
`timescale 1ns / 1ps
// short command queue between decode and execution
module llrb_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  llrb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output llrb_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import llrb_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? QAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QAW+1)'(QUEUE_DEPTH));

endmodule

/* rtl/llrb_back.sv */
`timescale 1ns / 1ps
// command execution: ring state, eviction scan, byte store and response register
module llrb_back #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  llrb_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_strobe,
   output llrb_pkg::rsp_type rsp_data
);
   import llrb_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int UW = AW + 1;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [POS_W-1:0]  oldest_ff, oldest_in;
   logic [POS_W-1:0]  write_ff, write_in;
   logic [POS_W-1:0]  drop_ff, drop_in;
   logic              open_ff, open_in;
   logic [AW-1:0]     plen_ff, plen_in;
   logic [AW-1:0]     pdone_ff, pdone_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              acc_ff, acc_in;
   logic              rdv_ff, rdv_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [7:0]        ram_rdata;

   logic [UW-1:0]     used;
   logic [AW-1:0]     cmd_len;
   logic              need_room;
   logic [POS_W-1:0]  drop_sat;
   logic [AW-1:0]     pdone_inc;
   logic [POS_W-1:0]  ahead_d;
   logic [POS_W-1:0]  beyond_d;
   logic              commit_ok;
   logic              scan_hit;
   logic              scan_last;

   llrb_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign used      = UW'(write_ff - oldest_ff);
   assign cmd_len   = cmd_ff.len[AW-1:0];
   assign need_room = ((UW+1)'(used) + (UW+1)'(cmd_len) + (UW+1)'(1)) > (UW+1)'(CAPACITY);
   assign drop_sat  = (drop_ff == '1) ? drop_ff : drop_ff + 32'd1;
   assign pdone_inc = pdone_ff + 1'b1;
   assign ahead_d   = cmd_ff.target - oldest_ff;
   assign beyond_d  = write_ff - cmd_ff.target;
   assign commit_ok = (ahead_d != '0) && !ahead_d[POS_W-1] && !beyond_d[POS_W-1];
   assign scan_hit  = (ram_rdata == NEWLINE);
   assign scan_last = ((UW'(idx_ff) + 1'b1) == used);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_BEGIN: state_in = cmd_ff.too_long ? ST_DONE : ST_ROOM;
               OP_BYTE: begin
                  state_in = (open_ff && pdone_inc == plen_ff) ? ST_NEWLINE : ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_ROOM:    state_in = need_room ? ST_SCAN : ST_DONE;
         ST_SCAN:    state_in = (scan_hit || scan_last) ? ST_ROOM : ST_SCAN;
         ST_NEWLINE: state_in = ST_DONE;
         ST_DONE:    state_in = q_empty ? ST_IDLE : ST_EXEC;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      oldest_in     = oldest_ff;
      write_in      = write_ff;
      drop_in       = drop_ff;
      open_in       = open_ff;
      plen_in       = plen_ff;
      pdone_in      = pdone_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      rdv_in        = rdv_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = write_ff[AW-1:0];
      ram_wdata     = NEWLINE;
      ram_re        = 1'b0;
      ram_raddr     = oldest_ff[AW-1:0];
      q_pop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               acc_in = 1'b0;
               rdv_in = 1'b0;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_BEGIN: begin
                  // an open line is abandoned either way
                  open_in = 1'b0;
                  if (cmd_ff.too_long) drop_in = drop_sat;
               end
               OP_BYTE: begin
                  if (open_ff) begin
                     ram_we    = 1'b1;
                     ram_waddr = write_ff[AW-1:0] + pdone_ff;
                     ram_wdata = cmd_ff.data;
                     pdone_in  = pdone_inc;
                     acc_in    = 1'b1;
                  end
               end
               OP_READ: begin
                  if (POS_W'(cmd_ff.offset) < POS_W'(used)) begin
                     ram_re    = 1'b1;
                     ram_raddr = oldest_ff[AW-1:0] + AW'(cmd_ff.offset);
                     rdv_in    = 1'b1;
                  end
               end
               OP_COMMIT: begin
                  if (commit_ok) begin
                     oldest_in = cmd_ff.target;
                     acc_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ROOM: begin
            if (need_room) begin
               ram_re    = 1'b1;
               ram_raddr = oldest_ff[AW-1:0];
               idx_in    = '0;
            end else begin
               plen_in  = cmd_len;
               pdone_in = '0;
               acc_in   = 1'b1;
               if (cmd_len == '0) begin
                  ram_we   = 1'b1;
                  write_in = write_ff + 32'd1;
               end else begin
                  open_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // prefetch the next byte while checking this one
            ram_re    = 1'b1;
            ram_raddr = oldest_ff[AW-1:0] + idx_ff + 1'b1;
            if (scan_hit) begin
               oldest_in = oldest_ff + POS_W'(idx_ff) + 32'd1;
               drop_in   = drop_sat;
            end else if (scan_last) begin
               oldest_in = write_ff;
               drop_in   = drop_sat;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_NEWLINE: begin
            ram_we    = 1'b1;
            ram_waddr = write_ff[AW-1:0] + plen_ff;
            write_in  = write_ff + POS_W'(plen_ff) + 32'd1;
            open_in   = 1'b0;
         end
         ST_DONE: begin
            rsp_strobe_in             = 1'b1;
            rsp_data_in.accepted      = acc_ff;
            rsp_data_in.read_valid    = rdv_ff;
            rsp_data_in.read_data     = rdv_ff ? ram_rdata : 8'd0;
            rsp_data_in.used_bytes    = USED_W'(write_ff - oldest_ff);
            rsp_data_in.base_pos      = oldest_ff;
            rsp_data_in.dropped_count = drop_ff;
            rsp_data_in.line_open     = open_ff;
            if (cmd_ff.op == OP_TAKE) drop_in = '0;
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               acc_in = 1'b0;
               rdv_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         write_ff      <= '0;
         drop_ff       <= '0;
         open_ff       <= 1'b0;
         plen_ff       <= '0;
         pdone_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         write_ff      <= write_in;
         drop_ff       <= drop_in;
         open_ff       <= open_in;
         plen_ff       <= plen_in;
         pdone_ff      <= pdone_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      rdv_ff      <= rdv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      (write_ff - oldest_ff) <= POS_W'(CAPACITY))
      else $error("bytes in use exceed ring capacity");

   // the last byte is in while the newline write is pending
   a_open_progress: assert property (@(posedge clock) disable iff (reset)
      (open_ff && (state_ff != ST_NEWLINE)) |-> (pdone_ff < plen_ff))
      else $error("open line already holds all its bytes");

   a_strobe_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_DONE))
      else $error("response strobe outside completion");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (used != '0))
      else $error("eviction scan over an empty ring");

endmodule

/* rtl/line_log_ring_buffer.sv */
`timescale 1ns / 1ps
// top level of the line log ring buffer
//
// a byte ring of whole log lines with 32-bit absolute oldest and write positions
// request channel: req_* fields are taken at a clock edge with start high and busy low;
//   func selects begin line, line byte, read byte, commit or take dropped count
// response channel: one transaction per request, in order, on the rsp_* ports for
//   exactly one cycle while rsp_strobe is high; the receiver cannot hold it off
// a decode stage pushes requests into a two-entry command queue; the execution unit
//   pops them and owns the ring state and the byte store's write and read ports
// sequence: a queued request is popped, executed, then completed, and rsp_strobe is
//   registered from completion; a line byte that completes its line adds the newline
//   write; a begin line adds a room check, and per evicted line a byte scan and a recheck
// requests are executed and completed one at a time while the queue takes new ones;
//   eviction scans stall the queue and busy rises when it fills
// reset: synchronous, clears positions, drop count, open line and the queue; the byte
//   store is not cleared, every byte in use has been written before it is read
module line_log_ring_buffer #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_line_len,
   input  logic [7:0]  req_data_byte,
   input  logic [9:0]  req_offset,
   input  logic [31:0] req_commit_base,
   input  logic [10:0] req_commit_count,
   // response channel
   output logic        rsp_strobe,
   output logic        rsp_accepted,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_data,
   output logic [10:0] rsp_used_bytes,
   output logic [31:0] rsp_base_pos,
   output logic [31:0] rsp_dropped_count,
   output logic        rsp_line_open
);
   import llrb_pkg::*;

   // decode to queue
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_full;

   // queue to execution
   logic    q_pop;
   logic    q_empty;
   cmd_type q_head;

   rsp_type rsp_data;

   // request decode and commit target add
   llrb_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .start            (start),
      .q_full           (q_full),
      .req_func         (req_func),
      .req_line_len     (req_line_len),
      .req_data_byte    (req_data_byte),
      .req_offset       (req_offset),
      .req_commit_base  (req_commit_base),
      .req_commit_count (req_commit_count),
      .busy             (busy),
      .push             (q_push),
      .push_cmd         (q_push_cmd)
   );

   // decouples decode from long eviction scans
   llrb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // ring state, byte store and registered response
   llrb_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // unpack the response transaction onto its ports
   assign rsp_accepted      = rsp_data.accepted;
   assign rsp_read_valid    = rsp_data.read_valid;
   assign rsp_read_data     = rsp_data.read_data;
   assign rsp_used_bytes    = rsp_data.used_bytes;
   assign rsp_base_pos      = rsp_data.base_pos;
   assign rsp_dropped_count = rsp_data.dropped_count;
   assign rsp_line_open     = rsp_data.line_open;

endmodule
